### sv/ccw_pkg.sv
// ----------------------------------------------------------------------------
// ccw_pkg : shared constants and types for the text console writer
// Map geometry, operation codes, control characters and the structs that
// travel between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ccw_pkg;

  // map geometry
  localparam int ROWS      = 32;
  localparam int COLUMNS   = 42;
  localparam int ROW_PITCH = 64;
  localparam int TAB_WIDTH = 3;

  localparam int MAP_BYTES = ROWS * ROW_PITCH;
  localparam int COPY_LEN  = (ROWS - 1) * ROW_PITCH;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int CNT_W     = $clog2(MAP_BYTES + 1);
  localparam int ROW_W     = $clog2(ROWS + 2);
  localparam int COL_W     = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int COL_MAX   = COLUMNS + TAB_WIDTH;

  // port field widths
  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 8;
  localparam int CUR_W  = 6;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_OUTPUT_ENABLE = 1'b0;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_RAW    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STR    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SETPOS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL_FIRST = 8'd10;
  localparam logic [CHAR_W-1:0] CH_NL_LAST  = 8'd13;
  localparam logic [CHAR_W-1:0] FILTER_MARK = 8'h3F;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor_row;
    logic [CUR_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_value;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] map_addr(input logic [ADDR_W-1:0] row,
                                                 input logic [ADDR_W-1:0] col);
    return ADDR_W'(row * ROW_PITCH + col);
  endfunction

endpackage

### sv/ccw_ram.sv
// ----------------------------------------------------------------------------
// ccw_ram : simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ccw_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/ccw_ctrl.sv
// ----------------------------------------------------------------------------
// ccw_ctrl : cursor and map sequencer
// Decodes one word per operation, moves the cursor, and drives the single
// map port. Scroll, clear and the post-reset wipe share one address sweep.
// ----------------------------------------------------------------------------
module ccw_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ccw_pkg::KIND_W-1:0]   in_kind,
  input  logic [ccw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [ccw_pkg::POS_W-1:0]    in_pos_x,
  input  logic [ccw_pkg::POS_W-1:0]    in_pos_y,
  input  logic                         output_enable,
  output logic                         res_valid,
  input  logic                         res_ready,
  output ccw_pkg::res_t                res,
  output ccw_pkg::mem_req_t            mem,
  input  logic [ccw_pkg::CHAR_W-1:0]   mem_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_READ, ST_SWEEP, ST_PUT, ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    SW_INIT, SW_CLEAR, SW_SCROLL
  } sweep_t;

  state_t                        state_r, state_nxt;
  sweep_t                        sweep_r, sweep_nxt;
  logic [ccw_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [ccw_pkg::CHAR_W-1:0]    code_r, code_nxt;
  logic [ccw_pkg::POS_W-1:0]     px_r, px_nxt;
  logic [ccw_pkg::POS_W-1:0]     py_r, py_nxt;
  logic [ccw_pkg::CHAR_W-1:0]    ch_r, ch_nxt;
  logic [ccw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [ccw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic                          skip_r, skip_nxt;
  logic [ccw_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic                          p1_valid_r, p1_valid_nxt;
  logic                          p1_copy_r, p1_copy_nxt;
  logic [ccw_pkg::ADDR_W-1:0]    p1_addr_r, p1_addr_nxt;
  logic                          rng_r, rng_nxt;
  logic [ccw_pkg::CHAR_W-1:0]    cell_r, cell_nxt;

  // filter decode
  logic                          do_print;
  logic                          skip_upd;
  logic [ccw_pkg::CHAR_W-1:0]    eff_ch;

  // wrap / scroll check
  logic [ccw_pkg::ROW_W-1:0]     w_row;
  logic [ccw_pkg::COL_W-1:0]     w_col;
  logic                          need_scroll;

  // character placement
  logic [ccw_pkg::ROW_W-1:0]     a_row, ap_row;
  logic [ccw_pkg::COL_W-1:0]     a_col, ap_col;
  logic [ccw_pkg::CHAR_W-1:0]    a_ch;
  logic                          ap_nl, ap_tab, ap_store;
  logic [ccw_pkg::ADDR_W-1:0]    ap_addr;

  logic                          fin;

  always_comb begin
    do_print = 1'b0;
    skip_upd = skip_r;
    eff_ch   = code_r;
    case (kind_r)
      ccw_pkg::KIND_RAW: begin
        do_print = output_enable;
      end
      ccw_pkg::KIND_STR: begin
        if (skip_r) begin
          skip_upd = 1'b0;
        end else if (code_r == ccw_pkg::CH_NUL) begin
          do_print = 1'b0;
        end else if (code_r[ccw_pkg::CHAR_W-1]) begin
          // top-bit byte: mark it and drop the byte that follows
          skip_upd = 1'b1;
          do_print = output_enable;
          eff_ch   = ccw_pkg::FILTER_MARK;
        end else begin
          do_print = output_enable;
        end
      end
      default: begin
        do_print = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (col_r >= ccw_pkg::COLUMNS) begin
      w_col = '0;
      w_row = row_r + ccw_pkg::ROW_W'(1);
    end else begin
      w_col = col_r;
      w_row = row_r;
    end
    need_scroll = (w_row >= ccw_pkg::ROWS);
  end

  always_comb begin
    if (state_r == ST_PUT) begin
      a_row = row_r;
      a_col = col_r;
      a_ch  = ch_r;
    end else begin
      a_row = w_row;
      a_col = w_col;
      a_ch  = eff_ch;
    end
    ap_nl    = (a_ch >= ccw_pkg::CH_NL_FIRST) && (a_ch <= ccw_pkg::CH_NL_LAST);
    ap_tab   = (a_ch == ccw_pkg::CH_TAB);
    ap_store = !ap_nl && !ap_tab && (a_col < ccw_pkg::ROW_PITCH);
    ap_addr  = ccw_pkg::map_addr(ccw_pkg::ADDR_W'(a_row), ccw_pkg::ADDR_W'(a_col));
    if (ap_nl) begin
      ap_row = a_row + ccw_pkg::ROW_W'(1);
      ap_col = '0;
    end else if (ap_tab) begin
      ap_row = a_row;
      ap_col = a_col + ccw_pkg::COL_W'(ccw_pkg::TAB_WIDTH);
    end else begin
      ap_row = a_row;
      ap_col = a_col + ccw_pkg::COL_W'(1);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    kind_nxt     = kind_r;
    code_nxt     = code_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    ch_nxt       = ch_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    skip_nxt     = skip_r;
    idx_nxt      = idx_r;
    p1_valid_nxt = 1'b0;
    p1_copy_nxt  = p1_copy_r;
    p1_addr_nxt  = p1_addr_r;
    rng_nxt      = rng_r;
    cell_nxt     = cell_r;
    fin          = 1'b0;
    res_valid    = 1'b0;
    in_ready     = (state_r == ST_IDLE);

    mem.we    = 1'b0;
    mem.waddr = ap_addr;
    mem.wdata = a_ch;
    mem.raddr = ccw_pkg::map_addr(ccw_pkg::ADDR_W'(py_r), ccw_pkg::ADDR_W'(px_r));

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          code_nxt  = in_char_code;
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cell_nxt = '0;
        case (kind_r)
          ccw_pkg::KIND_SETPOS: begin
            row_nxt = (py_r < ccw_pkg::ROWS) ? ccw_pkg::ROW_W'(py_r)
                                             : ccw_pkg::ROW_W'(ccw_pkg::ROWS - 1);
            col_nxt = (px_r < ccw_pkg::COLUMNS) ? ccw_pkg::COL_W'(px_r)
                                                : ccw_pkg::COL_W'(ccw_pkg::COLUMNS - 1);
            fin     = 1'b1;
          end
          ccw_pkg::KIND_CLEAR: begin
            row_nxt   = '0;
            col_nxt   = '0;
            idx_nxt   = '0;
            sweep_nxt = SW_CLEAR;
            state_nxt = ST_SWEEP;
          end
          ccw_pkg::KIND_READ: begin
            rng_nxt   = (py_r < ccw_pkg::ROWS) && (px_r < ccw_pkg::ROW_PITCH);
            state_nxt = ST_READ;
          end
          default: begin
            skip_nxt = skip_upd;
            if (do_print && need_scroll) begin
              // park the character, shift the map up, then place it
              row_nxt   = ccw_pkg::ROW_W'(ccw_pkg::ROWS - 1);
              col_nxt   = w_col;
              ch_nxt    = eff_ch;
              idx_nxt   = '0;
              sweep_nxt = SW_SCROLL;
              state_nxt = ST_SWEEP;
            end else begin
              if (do_print) begin
                mem.we  = ap_store;
                row_nxt = ap_row;
                col_nxt = ap_col;
              end
              fin = 1'b1;
            end
          end
        endcase
      end
      ST_READ: begin
        cell_nxt = rng_r ? mem_rdata : '0;
        fin      = 1'b1;
      end
      ST_SWEEP: begin
        if (idx_r != ccw_pkg::CNT_W'(ccw_pkg::MAP_BYTES)) begin
          mem.raddr    = ccw_pkg::ADDR_W'(idx_r) + ccw_pkg::ADDR_W'(ccw_pkg::ROW_PITCH);
          p1_valid_nxt = 1'b1;
          p1_addr_nxt  = idx_r[ccw_pkg::ADDR_W-1:0];
          p1_copy_nxt  = (sweep_r == SW_SCROLL) && (idx_r < ccw_pkg::COPY_LEN);
          idx_nxt      = idx_r + ccw_pkg::CNT_W'(1);
        end else begin
          unique case (sweep_r)
            SW_INIT:   state_nxt = ST_IDLE;
            SW_SCROLL: state_nxt = ST_PUT;
            SW_CLEAR: begin
              cell_nxt = '0;
              fin      = 1'b1;
            end
            default:   state_nxt = ST_IDLE;
          endcase
        end
        // write stage of the sweep, one word behind the read
        if (p1_valid_r) begin
          mem.we    = 1'b1;
          mem.waddr = p1_addr_r;
          mem.wdata = p1_copy_r ? mem_rdata : '0;
        end
      end
      ST_PUT: begin
        mem.we   = ap_store;
        row_nxt  = ap_row;
        col_nxt  = ap_col;
        cell_nxt = '0;
        fin      = 1'b1;
      end
      ST_HOLD: begin
        fin = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (res_ready) begin
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_HOLD;
      end
    end

    res.cursor_row = ccw_pkg::CUR_W'(row_nxt);
    res.cursor_col = ccw_pkg::CUR_W'(col_nxt);
    res.cell_value = cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      sweep_r    <= SW_INIT;
      row_r      <= '0;
      col_r      <= '0;
      skip_r     <= 1'b0;
      idx_r      <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      skip_r     <= skip_nxt;
      idx_r      <= idx_nxt;
      p1_valid_r <= p1_valid_nxt;
    end
    kind_r    <= kind_nxt;
    code_r    <= code_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    ch_r      <= ch_nxt;
    p1_copy_r <= p1_copy_nxt;
    p1_addr_r <= p1_addr_nxt;
    rng_r     <= rng_nxt;
    cell_r    <= cell_nxt;
  end

endmodule

### sv/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer : text-mode console character writer
// Character map with cursor, wrap, scroll, clear, cursor set and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one operation word: raw char,
//   filtered string byte, set cursor, clear or read cell. Output channel
//   (out_valid/out_ready) returns one word per operation: cursor after the
//   operation and, for a read, the cell contents.
//   A read cell waits for the registered map read. Scroll and clear sweep
//   the whole map one byte per cycle.
//   After reset the map is wiped by the same sweep, with in_ready low
//   until it ends; APB writes are taken meanwhile.
//   The result sits in an output register; the next operation is accepted
//   while it waits. If the receiver stalls, a finished operation holds the
//   sequencer until the output register frees.
//   APB register 0 bit 0: output enable (reset 1).
// ----------------------------------------------------------------------------
module text_console_char_writer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ccw_pkg::KIND_W-1:0]       in_kind,
  input  logic [ccw_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [ccw_pkg::POS_W-1:0]        in_pos_x,
  input  logic [ccw_pkg::POS_W-1:0]        in_pos_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ccw_pkg::CUR_W-1:0]        out_cursor_row,
  output logic [ccw_pkg::CUR_W-1:0]        out_cursor_col,
  output logic [ccw_pkg::CHAR_W-1:0]       out_cell_value,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ccw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ccw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ccw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic                 oe_r, oe_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ccw_pkg::res_t        out_r, out_nxt;
  logic                 res_valid;
  logic                 res_ready;
  ccw_pkg::res_t        res;
  ccw_pkg::mem_req_t    mem;
  logic [ccw_pkg::CHAR_W-1:0] mem_rdata;
  logic                 reg_hit;

  // configuration register
  assign reg_hit = (paddr[ccw_pkg::CFG_ADDR_W-1] == ccw_pkg::CFG_IDX_OUTPUT_ENABLE);
  assign pready  = 1'b1;

  always_comb begin
    oe_nxt = oe_r;
    if (psel && penable && pwrite && reg_hit) begin
      oe_nxt = pwdata[0];
    end
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(ccw_pkg::CFG_DATA_W-1){1'b0}}, oe_r};
    end
  end

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oe_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      oe_r        <= oe_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_r.cursor_row;
  assign out_cursor_col = out_r.cursor_col;
  assign out_cell_value = out_r.cell_value;

  ccw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .output_enable (oe_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem           (mem),
    .mem_rdata     (mem_rdata)
  );

  ccw_ram #(
    .DEPTH (ccw_pkg::MAP_BYTES),
    .WIDTH (ccw_pkg::CHAR_W)
  ) u_map (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // one word at a time through the sequencer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on the cycle after an accept");

  // map wipe runs after every reset before any word is taken
  a_wipe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_col <= ccw_pkg::CUR_W'(ccw_pkg::COL_MAX)))
    else $error("cursor column beyond wrap range");

  a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready)
    else $error("result produced into a full output register");
`endif

endmodule
